@@ rtl/vbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the stencil tap table for the volume bilaplacian core.
// No dependencies; every other file imports this package.
package vbs_pkg;

  localparam int OP_W       = 2;
  localparam int IN_CRD_W   = 5;
  localparam int CRD_W      = 6;
  localparam int SIZE_W     = 6;
  localparam int LOAD_W     = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 48;
  localparam int TAP_NUM    = 24;
  localparam int TAP_IDX_W  = 5;
  localparam int CLS_W      = 2;
  localparam int CLS_NUM    = 3;

  // Operation codes (in_tuser); the unused code behaves as a read
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;

  // Weight classes
  localparam logic [CLS_W-1:0] CLS_FACE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_AXIAL = 2'd1;
  localparam logic [CLS_W-1:0] CLS_EDGE  = 2'd2;

  localparam logic [TAP_IDX_W-1:0] TAP_LAST = TAP_IDX_W'(TAP_NUM - 1);
  localparam logic [CLS_W-1:0]     MUL_LAST = CLS_EDGE;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    logic signed [2:0] dz;
    logic [CLS_W-1:0]  cls;
  } tap_t;

  typedef enum logic [1:0] {
    RES_LOAD,
    RES_READ,
    RES_FILTER
  } res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                 start;
    logic                 ctr_rd;
    logic                 tap_rd;
    logic [TAP_IDX_W-1:0] tap_idx;
    logic                 mul;
    logic [CLS_W-1:0]     mul_idx;
    logic                 mul_first;
    logic                 res_load;
    logic                 mem_wr;
    res_sel_t             res_sel;
  } cmd_t;

  function automatic tap_t tap_get(input logic [TAP_IDX_W-1:0] idx);
    tap_t t;
    case (idx)
      5'd0:    t = '{ 3'sd1,  3'sd0,  3'sd0,  CLS_FACE};
      5'd1:    t = '{-3'sd1,  3'sd0,  3'sd0,  CLS_FACE};
      5'd2:    t = '{ 3'sd0,  3'sd1,  3'sd0,  CLS_FACE};
      5'd3:    t = '{ 3'sd0, -3'sd1,  3'sd0,  CLS_FACE};
      5'd4:    t = '{ 3'sd0,  3'sd0,  3'sd1,  CLS_FACE};
      5'd5:    t = '{ 3'sd0,  3'sd0, -3'sd1,  CLS_FACE};
      5'd6:    t = '{ 3'sd2,  3'sd0,  3'sd0,  CLS_AXIAL};
      5'd7:    t = '{-3'sd2,  3'sd0,  3'sd0,  CLS_AXIAL};
      5'd8:    t = '{ 3'sd0,  3'sd2,  3'sd0,  CLS_AXIAL};
      5'd9:    t = '{ 3'sd0, -3'sd2,  3'sd0,  CLS_AXIAL};
      5'd10:   t = '{ 3'sd0,  3'sd0,  3'sd2,  CLS_AXIAL};
      5'd11:   t = '{ 3'sd0,  3'sd0, -3'sd2,  CLS_AXIAL};
      5'd12:   t = '{ 3'sd1,  3'sd1,  3'sd0,  CLS_EDGE};
      5'd13:   t = '{ 3'sd1, -3'sd1,  3'sd0,  CLS_EDGE};
      5'd14:   t = '{-3'sd1,  3'sd1,  3'sd0,  CLS_EDGE};
      5'd15:   t = '{-3'sd1, -3'sd1,  3'sd0,  CLS_EDGE};
      5'd16:   t = '{ 3'sd1,  3'sd0,  3'sd1,  CLS_EDGE};
      5'd17:   t = '{ 3'sd1,  3'sd0, -3'sd1,  CLS_EDGE};
      5'd18:   t = '{-3'sd1,  3'sd0,  3'sd1,  CLS_EDGE};
      5'd19:   t = '{-3'sd1,  3'sd0, -3'sd1,  CLS_EDGE};
      5'd20:   t = '{ 3'sd0,  3'sd1,  3'sd1,  CLS_EDGE};
      5'd21:   t = '{ 3'sd0,  3'sd1, -3'sd1,  CLS_EDGE};
      5'd22:   t = '{ 3'sd0, -3'sd1,  3'sd1,  CLS_EDGE};
      5'd23:   t = '{ 3'sd0, -3'sd1, -3'sd1,  CLS_EDGE};
      default: t = '{ 3'sd0,  3'sd0,  3'sd0,  CLS_EDGE};
    endcase
    return t;
  endfunction

endpackage

@@ rtl/volume_biharmonic_stencil_update_core.sv @@
`timescale 1ns / 1ps
// Volume bilaplacian smoothing core: Q16.16 voxel store with load, read and
// in-place 24-tap filter items. Built from vbs_ctrl and vbs_dp; uses vbs_pkg.
//
// One item is in flight at a time. A filter item is captured, then its 24
// neighbours are read through the single read port of the voxel memory (one
// per cycle), the three class sums pass through the shared class-weight
// multiplier, the sum is finished, and the result is rounded, saturated,
// written back and presented. The result sits in an output register, so the
// next item is taken while it waits. The voxel memory has no reset and needs
// no clearing; every voxel must be loaded before it is read or used as a
// neighbour. Size registers may be written only when no item is in progress.
module volume_biharmonic_stencil_update_core #(
  parameter int SIDE_MAX         = 32,
  parameter int VALUE_BITS       = 32,
  parameter int WEIGHT_FRAC_BITS = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [4:0] voxel_x, [9:5] voxel_y, [14:10] voxel_z, [46:15] load_value, [47] zero
  input  logic [vbs_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] op
  input  logic [vbs_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] voxel_value
  output logic [vbs_pkg::OUT_W-1:0]         out_tdata,
  // [0] saturated
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vbs_pkg::SIZE_W-1:0]        cfg_data
);
  import vbs_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  vbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  vbs_dp #(
    .SIDE_MAX         (SIDE_MAX),
    .VALUE_BITS       (VALUE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_x      (in_tdata[4:0]),
    .in_y      (in_tdata[9:5]),
    .in_z      (in_tdata[14:10]),
    .in_load   ($signed(in_tdata[46:15])),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .out_value (out_tdata),
    .out_sat   (out_tuser)
  );

endmodule

@@ rtl/vbs_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the volume bilaplacian core: item acceptance, tap read
// sequence, multiply steps and result hand-off. Depends on vbs_pkg.
module vbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [vbs_pkg::OP_W-1:0] in_op,
  output logic              out_tvalid,
  input  logic              out_tready,
  output vbs_pkg::cmd_t     cmd
);
  import vbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_TAPS,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TAP_IDX_W-1:0]   tap_cnt_r, tap_cnt_nxt;
  logic [CLS_W-1:0]       mul_cnt_r, mul_cnt_nxt;
  res_sel_t               kind_r, kind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   res_free;

  assign res_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    tap_cnt_nxt = tap_cnt_r;
    mul_cnt_nxt = mul_cnt_r;
    kind_nxt    = kind_r;
    cmd         = '0;
    cmd.res_sel = kind_r;
    cmd.tap_idx = tap_cnt_r;
    cmd.mul_idx = mul_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          case (in_op)
            OP_LOAD: begin
              kind_nxt  = RES_LOAD;
              state_nxt = ST_DONE;
            end
            OP_FILTER: begin
              kind_nxt    = RES_FILTER;
              tap_cnt_nxt = '0;
              state_nxt   = ST_TAPS;
            end
            default: begin
              kind_nxt  = RES_READ;
              state_nxt = ST_RD;
            end
          endcase
        end
      end
      ST_RD: begin
        cmd.ctr_rd = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_TAPS: begin
        cmd.tap_rd = 1'b1;
        if (tap_cnt_r == TAP_LAST) begin
          mul_cnt_nxt = '0;
          state_nxt   = ST_MUL;
        end else begin
          tap_cnt_nxt = tap_cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul       = 1'b1;
        cmd.mul_first = (mul_cnt_r == CLS_FACE);
        if (mul_cnt_r == MUL_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          mul_cnt_nxt = mul_cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        // last product lands in the accumulator this cycle
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) begin
          cmd.res_load = 1'b1;
          cmd.mem_wr   = (kind_r != RES_READ);
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_cnt_r   <= '0;
      mul_cnt_r   <= '0;
      kind_r      <= RES_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while a transfer is pending");

  a_taps_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tap_rd && cmd.tap_idx == TAP_LAST) |=> (cmd.mul && cmd.mul_first))
    else $error("multiply sequence did not follow the last tap read");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.ctr_rd, cmd.tap_rd, cmd.mul, cmd.res_load}))
    else $error("more than one datapath command in a cycle");

  a_wr_with_res: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> (cmd.res_load && cmd.res_sel != RES_READ))
    else $error("voxel write outside a load or filter result");
`endif

endmodule

@@ rtl/vbs_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the volume bilaplacian core: size registers, voxel memory,
// class accumulators, shared multiplier, rounding and result register. Uses vbs_pkg.
module vbs_dp #(
  parameter int SIDE_MAX         = 32,
  parameter int VALUE_BITS       = 32,
  parameter int WEIGHT_FRAC_BITS = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vbs_pkg::cmd_t                     cmd,
  input  logic [vbs_pkg::IN_CRD_W-1:0]      in_x,
  input  logic [vbs_pkg::IN_CRD_W-1:0]      in_y,
  input  logic [vbs_pkg::IN_CRD_W-1:0]      in_z,
  input  logic signed [vbs_pkg::LOAD_W-1:0] in_load,
  input  logic                              cfg_we,
  input  logic [vbs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [vbs_pkg::SIZE_W-1:0]        cfg_val,
  output logic [vbs_pkg::OUT_W-1:0]         out_value,
  output logic                              out_sat
);
  import vbs_pkg::*;

  localparam int DEPTH = SIDE_MAX * SIDE_MAX * SIDE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = VALUE_BITS + 4;            // 12 samples per class at most
  localparam int WW    = WEIGHT_FRAC_BITS + 1;
  localparam int PW    = SW + WW;
  localparam int ACC_W = PW + 2;
  localparam int LW    = (VALUE_BITS > LOAD_W) ? VALUE_BITS : LOAD_W;
  localparam int XW    = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;

  localparam int W_FACE  = ((1 << (WEIGHT_FRAC_BITS + 2)) + 7) / 14;
  localparam int W_AXIAL = ((1 << (WEIGHT_FRAC_BITS + 1)) + 42) / 84;
  localparam int W_EDGE  = ((1 << (WEIGHT_FRAC_BITS + 1)) + 21) / 42;

  localparam logic signed [WW-1:0] WT_FACE  = WW'(W_FACE);
  localparam logic signed [WW-1:0] WT_AXIAL = -WW'(W_AXIAL);
  localparam logic signed [WW-1:0] WT_EDGE  = -WW'(W_EDGE);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (WEIGHT_FRAC_BITS - 1));
  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [SIZE_W-1:0]              size_r [CLS_NUM];
  logic [CRD_W-1:0]               lim_x, lim_y, lim_z;
  logic [CRD_W-1:0]               cx_r, cy_r, cz_r;
  logic signed [LOAD_W-1:0]       ld_r;
  tap_t                           tp;
  logic [CRD_W-1:0]               tx, ty, tz;
  logic [AW-1:0]                  addr_c, addr_t, rd_addr;
  logic                           rd_en;
  logic signed [VALUE_BITS-1:0]   vol_mem [DEPTH];
  logic signed [VALUE_BITS-1:0]   rdata_r;
  logic                           acc_vld_r;
  logic [CLS_W-1:0]               acc_cls_r;
  logic signed [SW-1:0]           sum_r [CLS_NUM];
  logic signed [SW-1:0]           mul_a;
  logic signed [WW-1:0]           mul_b;
  logic signed [PW-1:0]           prod_r;
  logic                           mul_vld_r, mul_first_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        rnd;
  logic                           rnd_fit;
  logic signed [LW-1:0]           ld_ext;
  logic                           ld_fit;
  logic signed [VALUE_BITS-1:0]   ld_val, flt_val, res_val;
  logic                           res_sat;
  logic signed [XW-1:0]           res_ext;
  logic [OUT_W-1:0]               out_value_r;
  logic                           out_sat_r;

  function automatic logic [CRD_W-1:0] lim_of(input logic [SIZE_W-1:0] s);
    logic [CRD_W-1:0] n;
    if (s == '0) begin
      n = CRD_W'(1);
    end else if (int'(s) > SIDE_MAX) begin
      n = CRD_W'(SIDE_MAX);
    end else begin
      n = s;
    end
    return n - 1'b1;
  endfunction

  function automatic logic [CRD_W-1:0] nb_clamp(input logic [CRD_W-1:0] c,
                                                input logic signed [2:0] d,
                                                input logic [CRD_W-1:0] lim);
    logic signed [CRD_W+1:0] t;
    t = $signed({2'b00, c}) + (CRD_W+2)'(d);
    if (t < 0) begin
      return '0;
    end else if (t > $signed({2'b00, lim})) begin
      return lim;
    end
    return t[CRD_W-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CRD_W-1:0] x,
                                            input logic [CRD_W-1:0] y,
                                            input logic [CRD_W-1:0] z);
    return AW'(z) * AW'(SIDE_MAX * SIDE_MAX) + AW'(y) * AW'(SIDE_MAX) + AW'(x);
  endfunction

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CLS_NUM; i++) size_r[i] <= SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIZE_X: size_r[0] <= cfg_val;
        REG_SIZE_Y: size_r[1] <= cfg_val;
        REG_SIZE_Z: size_r[2] <= cfg_val;
        default: ;
      endcase
    end
  end

  assign lim_x = lim_of(size_r[0]);
  assign lim_y = lim_of(size_r[1]);
  assign lim_z = lim_of(size_r[2]);

  // Item capture, centre coordinate clamped once
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx_r <= nb_clamp({1'b0, in_x}, 3'sd0, lim_x);
      cy_r <= nb_clamp({1'b0, in_y}, 3'sd0, lim_y);
      cz_r <= nb_clamp({1'b0, in_z}, 3'sd0, lim_z);
      ld_r <= in_load;
    end
  end

  assign tp      = tap_get(cmd.tap_idx);
  assign tx      = nb_clamp(cx_r, tp.dx, lim_x);
  assign ty      = nb_clamp(cy_r, tp.dy, lim_y);
  assign tz      = nb_clamp(cz_r, tp.dz, lim_z);
  assign addr_c  = addr_of(cx_r, cy_r, cz_r);
  assign addr_t  = addr_of(tx, ty, tz);
  assign rd_en   = cmd.ctr_rd || cmd.tap_rd;
  assign rd_addr = cmd.ctr_rd ? addr_c : addr_t;

  // Voxel memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      vol_mem[addr_c] <= res_val;
    end
    if (rd_en) begin
      rdata_r <= vol_mem[rd_addr];
    end
  end

  // Read data is registered; the accumulate and multiply valids are registered to match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.tap_rd;
      mul_vld_r <= cmd.mul;
    end
  end

  always_ff @(posedge clk) begin
    acc_cls_r   <= tp.cls;
    mul_first_r <= cmd.mul_first;
    for (int k = 0; k < CLS_NUM; k++) begin
      if (cmd.start) begin
        sum_r[k] <= '0;
      end else if (acc_vld_r && acc_cls_r == CLS_W'(k)) begin
        sum_r[k] <= sum_r[k] + SW'(rdata_r);
      end
    end
  end

  // Shared multiplier, one weight class per cycle
  always_comb begin
    case (cmd.mul_idx)
      CLS_FACE: begin
        mul_a = sum_r[0];
        mul_b = WT_FACE;
      end
      CLS_AXIAL: begin
        mul_a = sum_r[1];
        mul_b = WT_AXIAL;
      end
      default: begin
        mul_a = sum_r[2];
        mul_b = WT_EDGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mul_a * mul_b;
    end
    if (mul_vld_r) begin
      acc_r <= (mul_first_r ? HALF : acc_r) + ACC_W'(prod_r);
    end
  end

  // Round half up is folded into the accumulator start value
  assign rnd     = acc_r >>> WEIGHT_FRAC_BITS;
  assign rnd_fit = (&rnd[ACC_W-1:VALUE_BITS-1]) || !(|rnd[ACC_W-1:VALUE_BITS-1]);
  assign flt_val = rnd_fit ? rnd[VALUE_BITS-1:0] : (rnd[ACC_W-1] ? VMIN : VMAX);

  assign ld_ext  = LW'(ld_r);
  assign ld_fit  = (&ld_ext[LW-1:VALUE_BITS-1]) || !(|ld_ext[LW-1:VALUE_BITS-1]);
  assign ld_val  = ld_fit ? ld_ext[VALUE_BITS-1:0] : (ld_ext[LW-1] ? VMIN : VMAX);

  always_comb begin
    case (cmd.res_sel)
      RES_LOAD: begin
        res_val = ld_val;
        res_sat = 1'b0;
      end
      RES_FILTER: begin
        res_val = flt_val;
        res_sat = !rnd_fit;
      end
      default: begin
        res_val = rdata_r;
        res_sat = 1'b0;
      end
    endcase
  end

  assign res_ext = XW'(res_val);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_value_r <= res_ext[OUT_W-1:0];
      out_sat_r   <= res_sat;
    end
  end

  assign out_value = out_value_r;
  assign out_sat   = out_sat_r;

endmodule
